### design/cdb_pkg.sv
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared types and constants of the clone dab coverage blender.
// ----------------------------------------------------------------------------
`default_nettype none

package cdb_pkg;

    // default parameter values
    localparam int MAX_RADIUS_DEF = 64;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_HARDNESS = 2'd0;
    localparam logic [1:0] CFG_OPACITY  = 2'd1;
    localparam logic [1:0] CFG_IMG_W    = 2'd2;
    localparam logic [1:0] CFG_IMG_H    = 2'd3;

    localparam logic [6:0]  HARDNESS_RST = 7'd100;
    localparam logic [6:0]  OPACITY_RST  = 7'd100;
    localparam logic [10:0] IMG_W_RST    = 11'd1024;
    localparam logic [10:0] IMG_H_RST    = 11'd1024;

    localparam logic [6:0] HARD_EDGE   = 7'd95;
    localparam logic [6:0] PERCENT_MAX = 7'd100;
    localparam logic [8:0] COV_SCALE   = 9'd510;  // 2 * 255
    localparam int         SZW         = 13;      // holds sizes up to 4096

    // x / 200 for x below 2^16: ((x >> 3) * 10486) >> 18
    localparam int          COV_PRE_SH   = 3;
    localparam logic [13:0] COV_RECIP    = 14'd10486;
    localparam int          COV_RECIP_SH = 18;

    // opcodes
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_DAB   = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic signed [7:0] offset_x;
        logic signed [7:0] offset_y;
        logic [6:0]        dab_radius;
        logic signed [11:0] target_x;
        logic signed [11:0] target_y;
        logic              source_inside;
        logic              selection_ok;
        logic [31:0]       source_color;
        logic [31:0]       base_color;
    } t_in_item;

    typedef struct packed {
        logic        written;
        logic [31:0] out_color;
        logic [7:0]  coverage;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CHECK,
        S_EVAL,
        S_SQRT,
        S_DIV_GO,
        S_DIV,
        S_FALL,
        S_COV,
        S_COV2,
        S_CMP,
        S_BLEND,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_DIST,
        DIV_FALL
    } t_div_tag;

endpackage

`default_nettype wire

### design/clone_dab_coverage_blend.sv
// ----------------------------------------------------------------------------
// clone_dab_coverage_blend
// Clone stamp dab pixel blender with a per-pixel stroke coverage memory.
// ----------------------------------------------------------------------------
// One transaction at a time. The time a dab pixel takes from one acceptance to
// the next is set by the bit-serial square root and the shared bit-serial
// divider (distance and falloff divides). A pixel on the circle rim skips the
// root and the distance divide, a hard-edge pixel skips the root and both
// divides, and a skipped pixel goes straight to the output. A clear opcode
// sweeps the coverage memory one entry per cycle, all MAX_WIDTH*MAX_HEIGHT
// entries, before its result is shown; the same sweep runs after reset, while
// no input is accepted.
`default_nettype none

module clone_dab_coverage_blend #(
    parameter int MAX_RADIUS = cdb_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = cdb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cdb_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = cdb_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [10:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire cdb_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output cdb_pkg::t_out_item      o_out_item
);

    import cdb_pkg::*;

    localparam int RADW  = $clog2(MAX_RADIUS + 1);
    localparam int RW    = RADW + FRAC_BITS;
    localparam int SQW   = 2 * RW;
    localparam int DENW  = (RADW > 8) ? RADW : 8;
    localparam int NUMW  = FRAC_BITS + ((RADW > 7) ? RADW : 7) + 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = FRAC_BITS + 1;
    localparam int PW    = FW + 16;

    localparam logic [FW-1:0] ONE       = FW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF_TERM = PW'(100) << FRAC_BITS;

    t_state r_state, n_state;

    logic [6:0]  r_hardness;
    logic [6:0]  r_opacity;
    logic [10:0] r_img_w;
    logic [10:0] r_img_h;

    t_in_item         r_item;
    logic [AW-1:0]    r_clr_cnt;
    logic             r_clr_reply;
    logic [RADW-1:0]  r_r;
    logic [15:0]      r_d2;
    logic [2*RADW-1:0] r_rr;
    logic             r_skip;
    logic [15:0]      r_opw;
    logic [AW-1:0]    r_addr;
    logic [FW-1:0]    r_dist;
    logic [FW-1:0]    r_fall;
    logic [PW-1:0]    r_prod;
    logic [7:0]       r_cov;
    logic [NUMW-1:0]  r_dnum;
    logic [DENW-1:0]  r_dden;
    t_div_tag         r_tag;
    logic [15:0]      r_mix [4];
    t_out_item        r_out;

    // check stage
    logic [RADW-1:0]     w_r;
    logic signed [15:0]  w_sqx, w_sqy;
    logic [15:0]         w_d2;
    logic [SZW-1:0]      w_wlim, w_hlim;
    logic                w_outside;
    logic                w_skip;
    logic [AW-1:0]       w_addr;
    logic [6:0]          w_op;

    logic            w_in_acc;
    logic            w_sqrt_start, w_sqrt_done;
    logic [RW-1:0]   w_root;
    logic            w_div_start, w_div_done;
    logic [NUMW-1:0] w_quot;
    logic            w_mem_we, w_mem_re;
    logic [AW-1:0]   w_waddr;
    logic [7:0]      w_wdata, w_rdata;
    logic            w_wins;
    logic            w_eval_drop;
    logic [12:0]     w_cov_num;
    logic [26:0]     w_cov_prod;

    always_comb begin
        w_r = (32'(r_item.dab_radius) > MAX_RADIUS) ? RADW'(MAX_RADIUS)
                                                    : RADW'(r_item.dab_radius);
        w_sqx = r_item.offset_x * r_item.offset_x;
        w_sqy = r_item.offset_y * r_item.offset_y;
        w_d2  = $unsigned(w_sqx) + $unsigned(w_sqy);
        w_wlim = (32'(r_img_w) > MAX_WIDTH)  ? SZW'(MAX_WIDTH)  : SZW'(r_img_w);
        w_hlim = (32'(r_img_h) > MAX_HEIGHT) ? SZW'(MAX_HEIGHT) : SZW'(r_img_h);
        w_outside = r_item.target_x[11] || r_item.target_y[11]
                 || (SZW'(r_item.target_x[10:0]) >= w_wlim)
                 || (SZW'(r_item.target_y[10:0]) >= w_hlim);
        w_skip = (r_item.dab_radius == 7'd0) || w_outside
              || !r_item.source_inside || !r_item.selection_ok;
        w_addr = AW'(32'(r_item.target_y[10:0]) * 32'(MAX_WIDTH)
                     + 32'(r_item.target_x[10:0]));
        w_op = (r_opacity > PERCENT_MAX) ? PERCENT_MAX : r_opacity;
        w_eval_drop = r_skip || (32'(r_d2) > 32'(r_rr));
        w_wins = (r_cov != 8'd0) && (r_cov > w_rdata);
        // rounded numerator stays below 2^16, so the reciprocal is exact
        w_cov_num  = 13'((r_prod + HALF_TERM) >> (FRAC_BITS + COV_PRE_SH));
        w_cov_prod = 27'(w_cov_num) * 27'(COV_RECIP);
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        w_sqrt_start = 1'b0;
        w_div_start  = 1'b0;
        w_mem_re     = 1'b0;
        w_mem_we     = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = r_cov;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = (i_in_item.opcode == OP_CLEAR) ? S_CLEAR : S_CHECK;
                end
            end
            S_CLEAR: begin
                w_mem_we = 1'b1;
                w_waddr  = r_clr_cnt;
                w_wdata  = 8'd0;
                if (r_clr_cnt == AW'(DEPTH - 1)) begin
                    n_state = r_clr_reply ? S_OUT : S_IDLE;
                end
            end
            S_CHECK: begin
                w_mem_re = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                priority if (w_eval_drop) begin
                    n_state = S_OUT;
                end else if (r_hardness >= HARD_EDGE) begin
                    n_state = S_COV;
                end else if (32'(r_d2) == 32'(r_rr)) begin
                    n_state = S_FALL;
                end else begin
                    w_sqrt_start = 1'b1;
                    n_state      = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_sqrt_done) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    unique case (r_tag)
                        DIV_DIST: n_state = S_FALL;
                        DIV_FALL: n_state = S_COV;
                        default:  n_state = S_COV;
                    endcase
                end
            end
            S_FALL:  n_state = S_DIV_GO;
            S_COV:   n_state = S_COV2;
            S_COV2:  n_state = S_CMP;
            S_CMP: begin
                w_mem_we = w_wins;
                n_state  = w_wins ? S_BLEND : S_OUT;
            end
            S_BLEND: n_state = S_OUT;
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_in_acc = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hardness <= HARDNESS_RST;
            r_opacity  <= OPACITY_RST;
            r_img_w    <= IMG_W_RST;
            r_img_h    <= IMG_H_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HARDNESS: r_hardness <= i_cfg_data[6:0];
                CFG_OPACITY:  r_opacity  <= i_cfg_data[6:0];
                CFG_IMG_W:    r_img_w    <= i_cfg_data;
                CFG_IMG_H:    r_img_h    <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // clear sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_clr_reply <= 1'b0;
        end else if (w_in_acc) begin
            r_clr_cnt   <= '0;
            r_clr_reply <= 1'b1;
        end else if (r_state == S_CLEAR) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_item;
            r_out  <= '0;
        end
        unique case (r_state)
            S_CHECK: begin
                r_r    <= w_r;
                r_d2   <= w_d2;
                r_rr   <= w_r * w_r;
                r_skip <= w_skip;
                r_addr <= w_addr;
                r_opw  <= 16'(w_op) * 16'(COV_SCALE);
            end
            S_EVAL: begin
                if (r_hardness >= HARD_EDGE) begin
                    r_fall <= ONE;
                end
                r_dist <= ONE;
            end
            S_SQRT: begin
                r_dnum <= NUMW'(w_root);
                r_dden <= DENW'(r_r);
                r_tag  <= DIV_DIST;
            end
            S_DIV: begin
                if (w_div_done) begin
                    unique case (r_tag)
                        DIV_DIST: r_dist <= FW'(w_quot);
                        DIV_FALL: r_fall <= (w_quot > NUMW'(ONE)) ? ONE : FW'(w_quot);
                        default:  ;
                    endcase
                end
            end
            S_FALL: begin
                r_dnum <= NUMW'(ONE - r_dist) * NUMW'(PERCENT_MAX);
                r_dden <= DENW'(PERCENT_MAX - r_hardness);
                r_tag  <= DIV_FALL;
            end
            S_COV: begin
                r_prod <= PW'(r_fall) * PW'(r_opw);
            end
            S_COV2: begin
                r_cov <= w_cov_prod[COV_RECIP_SH +: 8];
            end
            S_CMP: begin
                for (int c = 0; c < 4; c++) begin
                    r_mix[c] <= 16'(r_item.source_color[8*c +: 8]) * 16'(r_cov)
                              + 16'(r_item.base_color[8*c +: 8]) * 16'(8'd255 - r_cov);
                end
            end
            S_BLEND: begin
                r_out.written  <= 1'b1;
                r_out.coverage <= r_cov;
                // x / 255 for x below 2^16
                for (int c = 0; c < 4; c++) begin
                    r_out.out_color[8*c +: 8] <=
                        8'((17'(r_mix[c]) + 17'(r_mix[c][15:8]) + 17'd1) >> 8);
                end
            end
            default: ;
        endcase
    end

    cdb_isqrt #(
        .RW (RW)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (SQW'(r_d2) << (2 * FRAC_BITS)),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    cdb_div #(
        .NUMW (NUMW),
        .DENW (DENW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    cdb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_cov_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign o_out_item = r_out;

    // assertions
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while a result is pending");

    a_written_has_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.written) |-> (o_out_item.coverage != 8'd0))
        else $error("written pixel with zero coverage");

    a_skip_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.written)
            |-> (o_out_item.coverage == 8'd0 && o_out_item.out_color == 32'd0))
        else $error("skipped pixel carries data");

    a_no_mem_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> !o_in_ready)
        else $error("coverage memory written while idle");

endmodule

`default_nettype wire

### design/cdb_ram.sv
// ----------------------------------------------------------------------------
// cdb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### design/cdb_isqrt.sv
// ----------------------------------------------------------------------------
// cdb_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cdb_isqrt #(
    parameter int RW = 23
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [2*RW-1:0] i_radicand,
    output logic                 o_done,
    output logic      [RW-1:0]   o_root
);

    localparam int CW  = $clog2(RW + 1);
    localparam int RMW = RW + 3;

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [2*RW-1:0] r_rad;
    logic [RMW-1:0]  r_rem;
    logic [RW-1:0]   r_root;

    logic [RMW-1:0]  w_rem_sh;
    logic [RMW-1:0]  w_trial;
    logic            w_ge;

    always_comb begin
        w_rem_sh = {r_rem[RMW-3:0], r_rad[2*RW-1 -: 2]};
        w_trial  = RMW'({r_root, 2'b01});
        w_ge     = (w_rem_sh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[RW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

### design/cdb_div.sv
// ----------------------------------------------------------------------------
// cdb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cdb_div #(
    parameter int NUMW = 24,
    parameter int DENW = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [NUMW-1:0] i_num,
    input  wire logic [DENW-1:0] i_den,
    output logic                 o_done,
    output logic      [NUMW-1:0] o_quot
);

    localparam int CW = $clog2(NUMW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [NUMW-1:0] r_num;
    logic [DENW-1:0] r_den;
    logic [DENW-1:0] r_rem;
    logic [NUMW-1:0] r_quot;

    logic [DENW:0]   w_rem_sh;
    logic [DENW:0]   w_diff;
    logic            w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_num[NUMW-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
        w_diff   = w_rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NUMW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= r_num << 1;
            r_rem  <= w_ge ? w_diff[DENW-1:0] : w_rem_sh[DENW-1:0];
            r_quot <= {r_quot[NUMW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire
